FILE: sv/utbd_pkg.sv
// package: constants, types and digit character and radix clamp functions for the base digit converter
`timescale 1ns / 1ps
`default_nettype none
package utbd_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int IN_W        = 64;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_BITS    = DIV_STEPS * DIV_BITS;
    localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int STORE_DEPTH = VALUE_BITS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_EMIT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_init;
        logic rd_step;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
        logic quot_zero;
        logic idx_zero;
        logic pipe_busy;
    } t_dp_sts;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
                                                        input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER : CHAR_LOWER;
        if (d < DIGIT_TEN) begin
            digit_to_char = CHAR_ZERO + CHAR_W'(d);
        end else begin
            digit_to_char = base + CHAR_W'(d - DIGIT_TEN);
        end
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            clamp_radix = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            clamp_radix = RADIX_MAX;
        end else begin
            clamp_radix = r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/utbd_ctrl.sv
// controller state machine: sequences division, digit store and digit emission
`timescale 1ns / 1ps
`default_nettype none
module utbd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  utbd_pkg::t_dp_sts   i_sts,
    output utbd_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);

    utbd_pkg::t_state r_state;
    utbd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utbd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            utbd_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = utbd_pkg::ST_DIV;
                end
            end
            utbd_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = utbd_pkg::ST_CHECK;
                end
            end
            utbd_pkg::ST_CHECK: begin
                if (i_sts.quot_zero) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = utbd_pkg::ST_EMIT;
                end else begin
                    n_state = utbd_pkg::ST_DIV;
                end
            end
            utbd_pkg::ST_EMIT: begin
                o_cmd.rd_step = 1'b1;
                if (i_sts.idx_zero) begin
                    n_state = utbd_pkg::ST_DRAIN;
                end
            end
            utbd_pkg::ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = utbd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = utbd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != utbd_pkg::ST_IDLE);

endmodule
`default_nettype wire

FILE: sv/utbd_dp.sv
// datapath: byte-serial divider by radix, digit memory and character output stage
`timescale 1ns / 1ps
`default_nettype none
module utbd_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  utbd_pkg::t_dp_cmd                     i_cmd,
    output utbd_pkg::t_dp_sts                     o_sts,
    input  wire [utbd_pkg::IN_W-1:0]              i_value,
    input  wire [utbd_pkg::RADIX_W-1:0]           i_radix,
    input  wire                                   i_upper,
    output logic                                  o_valid,
    output logic [utbd_pkg::CHAR_W-1:0]           o_digit_char,
    output logic                                  o_last
);

    logic [utbd_pkg::PAD_BITS-1:0]  r_quot;
    logic [utbd_pkg::PAD_BITS-1:0]  n_quot;
    logic [utbd_pkg::DIGIT_W-1:0]   r_rem;
    logic [utbd_pkg::DIGIT_W-1:0]   n_rem;
    logic [utbd_pkg::STEP_W-1:0]    r_step;
    logic [utbd_pkg::CNT_W-1:0]     r_count;
    logic [utbd_pkg::RADIX_W-1:0]   r_radix;
    logic [utbd_pkg::ADDR_W-1:0]    r_rd_idx;
    logic [utbd_pkg::DIGIT_W-1:0]   r_rd_data;
    logic                           r_rd_vld;
    logic                           r_rd_last;
    logic                           r_out_vld;
    logic [utbd_pkg::CHAR_W-1:0]    r_out_char;
    logic                           r_out_last;
    logic [utbd_pkg::DIGIT_W-1:0]   r_mem [utbd_pkg::STORE_DEPTH];

    logic [utbd_pkg::DIV_BITS-1:0]  w_top;
    logic [utbd_pkg::DIV_BITS-1:0]  w_qbits;
    logic [utbd_pkg::DIGIT_W:0]     w_part;
    logic                           w_last_step;

    // one quotient byte per cycle while div_step is set, remainder stays below the radix
    always_comb begin
        w_top   = r_quot[utbd_pkg::PAD_BITS-1 -: utbd_pkg::DIV_BITS];
        w_qbits = '0;
        n_rem   = r_rem;
        w_part  = '0;
        for (int j = utbd_pkg::DIV_BITS - 1; j >= 0; j--) begin
            w_part = {n_rem, w_top[j]};
            if (w_part >= r_radix) begin
                w_part     = w_part - r_radix;
                w_qbits[j] = 1'b1;
            end
            n_rem = w_part[utbd_pkg::DIGIT_W-1:0];
        end
        n_quot = (r_quot << utbd_pkg::DIV_BITS) | utbd_pkg::PAD_BITS'(w_qbits);
    end

    assign w_last_step = (r_step == utbd_pkg::STEP_W'(utbd_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_step  <= '0;
                r_count <= '0;
            end else if (i_cmd.div_step) begin
                if (w_last_step) begin
                    r_step  <= '0;
                    r_count <= r_count + 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (i_cmd.emit_init) begin
                r_rd_idx <= utbd_pkg::ADDR_W'(r_count - 1'b1);
            end else if (i_cmd.rd_step) begin
                r_rd_idx <= r_rd_idx - 1'b1;
            end
            r_rd_vld  <= i_cmd.rd_step;
            r_out_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot  <= utbd_pkg::PAD_BITS'(i_value[utbd_pkg::VALUE_BITS-1:0]);
            r_rem   <= '0;
            r_radix <= utbd_pkg::clamp_radix(i_radix);
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
            r_rem  <= w_last_step ? '0 : n_rem;
        end
        if (i_cmd.rd_step) begin
            r_rd_last <= (r_rd_idx == '0);
        end
        r_out_char <= utbd_pkg::digit_to_char(r_rd_data, i_upper);
        r_out_last <= r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && w_last_step) begin
            r_mem[r_count[utbd_pkg::ADDR_W-1:0]] <= n_rem;
        end
        if (i_cmd.rd_step) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_sts.last_step = w_last_step;
    assign o_sts.quot_zero = (r_quot == '0);
    assign o_sts.idx_zero  = (r_rd_idx == '0);
    assign o_sts.pipe_busy = r_rd_vld | r_out_vld;

    assign o_valid      = r_out_vld;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

endmodule
`default_nettype wire

FILE: sv/unsigned_to_base_digits_core.sv
// top level: configuration registers, controller and datapath of the base digit converter
//
//  channel   direction  signals                                      transaction
//  command   in         start, busy, i_value                         start & !busy
//  result    out        o_valid, o_digit_char, o_last                o_valid (one cycle)
//  config    in         i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data   valid & ready
//
//  each digit takes 8 division steps (one quotient byte per cycle through the radix divider,
//  plus a zero test per digit)
//  digits leave at one per cycle, most significant first, registered in r_rd_data then r_out_char
//  synchronous active-low reset clears control state; radix resets to 10, lower case letters
//  results cannot be stalled; busy stays high until the last digit has been shown
`timescale 1ns / 1ps
`default_nettype none
module unsigned_to_base_digits_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [utbd_pkg::IN_W-1:0]            i_value,
    output logic                                o_valid,
    output logic [utbd_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                                o_last,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [utbd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [utbd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [utbd_pkg::RADIX_W-1:0] r_radix;
    logic                         r_upper;
    utbd_pkg::t_dp_cmd            w_cmd;
    utbd_pkg::t_dp_sts            w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= utbd_pkg::RADIX_RST;
            r_upper <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                utbd_pkg::REG_RADIX: begin
                    r_radix <= i_cfg_data[utbd_pkg::RADIX_W-1:0];
                end
                utbd_pkg::REG_UPPER: begin
                    r_upper <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    utbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    utbd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value      (i_value),
        .i_radix      (r_radix),
        .i_upper      (r_upper),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

FILE: sv/utbd_checker.sv
// port checker for the base digit converter and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
module utbd_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              start,
    input wire                              busy,
    input wire                              o_valid,
    input wire [utbd_pkg::CHAR_W-1:0]       o_digit_char,
    input wire                              o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("digit shown while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("digit after last digit");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_valid && o_last, 2))
        else $error("busy dropped without a last digit");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= 7'd48 && o_digit_char <= 7'd57) ||
                     (o_digit_char >= 7'd65 && o_digit_char <= 7'd70) ||
                     (o_digit_char >= 7'd97 && o_digit_char <= 7'd102)))
        else $error("digit character out of range");

endmodule

bind unsigned_to_base_digits_core utbd_checker u_utbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_digit_char (o_digit_char),
    .o_last       (o_last)
);
`default_nettype wire
